@@ design/cmp_pkg.sv @@
package cmp_pkg;

   // Field widths
   localparam int MODE_W = 2;
   localparam int DATA_W = 8;
   localparam int ADDR_IN_W = 16;
   localparam int SIZE_W = 17;
   localparam int POS_W = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int CART_SLOTS = 2;

   // Defaults for the top-level parameters
   localparam int MEM_BYTES_DEFAULT = 65536;
   localparam int SLOT_COUNT_DEFAULT = 2;

   // Item modes
   typedef enum logic [MODE_W-1:0] {
      MODE_CMD     = 2'd0,
      MODE_ACCESS  = 2'd1,
      MODE_PRELOAD = 2'd2,
      MODE_IDLE    = 2'd3
   } mode_type;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT0_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT1_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT0_PRESENT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT1_PRESENT = 2'd3;

   // Command opcodes (upper nibble of the command byte)
   localparam logic [3:0] CMD_ZERO = 4'h0;
   localparam logic [3:0] CMD_SEEK = 4'hA;
   localparam logic [3:0] CMD_READ_DEC = 4'h1;
   localparam logic [3:0] CMD_READ_INC = 4'hD;
   localparam logic [3:0] CMD_WRITE = 4'h2;
   localparam logic [3:0] CMD_WRITE_ALT_C = 4'hC;
   localparam logic [3:0] CMD_WRITE_ALT_E = 4'hE;

   // Bit inside the command byte that picks the pointer direction
   localparam int CMD_READ_DIR_BIT = 7;
   localparam int CMD_WRITE_DIR_BIT = 4;

   localparam logic [DATA_W-1:0] BYTE_ABSENT = 8'hFF;
   localparam logic [DATA_W-1:0] BYTE_ZERO = 8'h00;

   // Size limit below which the cartridge is writable and wraps at 16 bits
   localparam logic [SIZE_W-1:0] SMALL_LIMIT = 17'h08000;

endpackage

@@ design/cmp_ram.sv @@
module cmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/cartridge_memory_port.sv @@
// Channel   Ports                                     Direction  Beat taken when
// ------    ----------------------------------------  ---------  ---------------------
// request   req_mode req_slot req_value req_load_addr  in         start && !busy
// response  rsp_read_byte rsp_slot_dirty               out        rsp_strobe (one cycle)
// csr       csr_we csr_index csr_wdata                 in         csr_we
//
// One request beat per cycle is taken while busy is low; its response beat shows up
// on the cycle right after acceptance, via the registered read of the cartridge RAM.
// Reset is synchronous and active high; busy follows reset, so no beat is taken while
// it is held. The cartridge RAM is not cleared by reset: bytes come from preload or
// data writes. The response side cannot stall; a response is shown for one cycle only.
module cartridge_memory_port #(
   parameter int MEM_BYTES = cmp_pkg::MEM_BYTES_DEFAULT,
   parameter int SLOT_COUNT = cmp_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             start,
   output logic                             busy,
   input  logic [cmp_pkg::MODE_W-1:0]       req_mode,
   input  logic                             req_slot,
   input  logic [cmp_pkg::DATA_W-1:0]       req_value,
   input  logic [cmp_pkg::ADDR_IN_W-1:0]    req_load_addr,

   output logic                             rsp_strobe,
   output logic [cmp_pkg::DATA_W-1:0]       rsp_read_byte,
   output logic                             rsp_slot_dirty,

   input  logic                             csr_we,
   input  logic [cmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cmp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import cmp_pkg::*;

   // Slots that really exist; the slot field and the csr map cover two.
   localparam int NSLOT = (SLOT_COUNT < CART_SLOTS) ? SLOT_COUNT : CART_SLOTS;
   localparam int RAM_DEPTH = NSLOT * MEM_BYTES;
   localparam int RAM_AW = $clog2(RAM_DEPTH);
   localparam logic [POS_W:0] MEM_BYTES_W = (POS_W + 1)'(MEM_BYTES);

   // Per-slot control state
   logic [DATA_W-1:0] cmd_ff [CART_SLOTS];
   logic [DATA_W-1:0] cmd_in [CART_SLOTS];
   logic [POS_W-1:0]  pos_ff [CART_SLOTS];
   logic [POS_W-1:0]  pos_in [CART_SLOTS];
   logic              dirty_ff [CART_SLOTS];
   logic              dirty_in [CART_SLOTS];
   logic [SIZE_W-1:0] size_ff [CART_SLOTS];
   logic              present_ff [CART_SLOTS];

   // Response stage
   logic              strobe_ff;
   logic              use_ram_ff;
   logic [DATA_W-1:0] res_ff;
   logic              dirty_out_ff;

   // Decode of the accepted beat
   logic              accept;
   mode_type          mode;
   logic              slot_ok;
   logic [DATA_W-1:0] cmd;
   logic [POS_W-1:0]  pos;
   logic [SIZE_W-1:0] size;
   logic              compact;
   logic              in_size;
   logic              in_mem;
   logic [POS_W-1:0]  pos_inc;
   logic [POS_W-1:0]  pos_dec;
   logic [POS_W-1:0]  pos_seek;
   logic [POS_W-1:0]  pos_next;
   logic              pos_wr;
   logic              cmd_wr;
   logic              dirty_set;
   logic              use_ram;
   logic [DATA_W-1:0] res;
   logic              ram_we;
   logic [POS_W-1:0]  offset;
   logic [POS_W:0]    base;
   logic [POS_W:0]    addr_sum;
   logic [DATA_W-1:0] ram_rdata;

   assign busy = reset;
   assign accept = start && !busy;
   assign mode = mode_type'(req_mode);
   assign slot_ok = (req_slot == 1'b0) || (NSLOT > 1);

   assign cmd = cmd_ff[req_slot];
   assign pos = pos_ff[req_slot];
   assign size = size_ff[req_slot];
   assign compact = size < SMALL_LIMIT;
   assign in_size = pos < {{(POS_W - SIZE_W){1'b0}}, size};
   assign in_mem = {1'b0, pos} < MEM_BYTES_W;

   // Wrap at 16 bits for small cartridges, 24 bits otherwise
   function automatic logic [POS_W-1:0] wrap(input logic [POS_W-1:0] p, input logic sm);
      logic [POS_W-1:0] r;
      r = sm ? {{(POS_W - 16){1'b0}}, p[15:0]} : p;
      return r;
   endfunction

   assign pos_inc = wrap(pos + POS_W'(1), compact);
   assign pos_dec = wrap(pos - POS_W'(1), compact);
   assign pos_seek = wrap({pos[POS_W-DATA_W-1:0], req_value}, compact);

   // Work out what the beat does to the slot and the RAM
   always_comb begin
      cmd_wr = 1'b0;
      pos_wr = 1'b0;
      pos_next = pos;
      dirty_set = 1'b0;
      use_ram = 1'b0;
      res = BYTE_ZERO;
      ram_we = 1'b0;
      offset = pos;
      case (mode)
         MODE_CMD: begin
            cmd_wr = slot_ok;
         end
         MODE_ACCESS: begin
            res = BYTE_ABSENT;
            if (slot_ok && present_ff[req_slot]) begin
               case (cmd[7:4])
                  CMD_ZERO: begin
                     res = BYTE_ZERO;
                  end
                  CMD_SEEK: begin
                     pos_wr = 1'b1;
                     pos_next = pos_seek;
                  end
                  CMD_READ_DEC, CMD_READ_INC: begin
                     pos_wr = 1'b1;
                     pos_next = cmd[CMD_READ_DIR_BIT] ? pos_inc : pos_dec;
                     use_ram = in_size && in_mem;
                     res = BYTE_ZERO;
                  end
                  CMD_WRITE, CMD_WRITE_ALT_C, CMD_WRITE_ALT_E: begin
                     pos_wr = 1'b1;
                     pos_next = cmd[CMD_WRITE_DIR_BIT] ? pos_dec : pos_inc;
                     ram_we = in_size && compact && in_mem;
                     dirty_set = ram_we;
                  end
                  default: begin
                     res = BYTE_ABSENT;
                  end
               endcase
            end
         end
         MODE_PRELOAD: begin
            offset = {{(POS_W - ADDR_IN_W){1'b0}}, req_load_addr};
            ram_we = slot_ok && ({{(POS_W - ADDR_IN_W + 1){1'b0}}, req_load_addr} < MEM_BYTES_W);
         end
         MODE_IDLE: begin
            res = BYTE_ZERO;
         end
         default: begin
            res = BYTE_ZERO;
         end
      endcase
   end

   // Next values for the per-slot registers
   always_comb begin
      for (int i = 0; i < CART_SLOTS; i++) begin
         cmd_in[i] = cmd_ff[i];
         pos_in[i] = pos_ff[i];
         dirty_in[i] = dirty_ff[i];
      end
      if (accept) begin
         if (cmd_wr) begin
            cmd_in[req_slot] = req_value;
         end
         if (pos_wr) begin
            pos_in[req_slot] = pos_next;
         end
         if (dirty_set) begin
            dirty_in[req_slot] = 1'b1;
         end
      end
   end

   // Slot base plus offset into the shared cartridge RAM
   assign base = req_slot ? MEM_BYTES_W : '0;
   assign addr_sum = base + {1'b0, offset};

   cmp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (accept && ram_we),
      .addr  (addr_sum[RAM_AW-1:0]),
      .wdata (req_value),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CART_SLOTS; i++) begin
            cmd_ff[i] <= '0;
            pos_ff[i] <= '0;
            dirty_ff[i] <= 1'b0;
            size_ff[i] <= '0;
            present_ff[i] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         for (int i = 0; i < CART_SLOTS; i++) begin
            cmd_ff[i] <= cmd_in[i];
            pos_ff[i] <= pos_in[i];
            dirty_ff[i] <= dirty_in[i];
         end
         // Hold configuration until the next csr write
         if (csr_we) begin
            case (csr_index)
               CSR_SLOT0_SIZE: size_ff[0] <= csr_wdata[SIZE_W-1:0];
               CSR_SLOT1_SIZE: size_ff[1] <= csr_wdata[SIZE_W-1:0];
               CSR_SLOT0_PRESENT: present_ff[0] <= csr_wdata[0];
               CSR_SLOT1_PRESENT: present_ff[1] <= csr_wdata[0];
               default: ;
            endcase
         end
         strobe_ff <= accept;
      end
   end

   // Response payload: no reset needed, qualified by the strobe
   always_ff @(posedge clock) begin
      if (accept) begin
         use_ram_ff <= use_ram;
         res_ff <= res;
         dirty_out_ff <= slot_ok && (dirty_ff[req_slot] || dirty_set);
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_read_byte = use_ram_ff ? ram_rdata : res_ff;
   assign rsp_slot_dirty = dirty_out_ff;

endmodule

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cmp_pkg::*;

   localparam int CART_BYTES = MEM_BYTES_DEFAULT;
   localparam int STALL_LIMIT = 4000;   // quiet cycles before the run is declared hung
   localparam int DRAIN_CYCLES = 3;     // slack after the last response is in
   localparam int PHASES = 12;
   localparam int PHASE_BEATS = 135;
   localparam int REPORT_CAP = 40;      // keep the log short if the block is badly broken
   localparam int PLAN_ROWS = 32;

   // One request beat and one response beat, at the block's own widths
   typedef struct {
      mode_type      mode;
      bit            slot;
      bit [7:0]      value;
      bit [15:0]     load_addr;
   } cart_req_type;

   typedef struct {
      bit [7:0]      read_byte;
      bit            slot_dirty;
   } cart_rsp_type;

   // Directed plan: either a request beat or a register write
   typedef enum bit {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   csr_idx;
      mode_type               mode;
      bit                     slot;
      bit [7:0]               value;
      bit [16:0]              word;        // register data, or the preload address
      bit                     typed;       // expected response given in the row
      bit [7:0]               want_byte;
      bit                     want_dirty;
   } plan_row_type;

   // Slot 0 starts tiny and writable, slot 1 full size and read-only; slot 1 is
   // brought in for the last rows. Dirty and position carry across the rows.
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_CSR,  CSR_SLOT0_SIZE,    MODE_IDLE,    1'b0, 8'h00, 17'd4,     1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_SLOT0_PRESENT, MODE_IDLE,    1'b0, 8'h00, 17'd1,     1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_SLOT1_SIZE,    MODE_IDLE,    1'b0, 8'h00, 17'd65536, 1'b0, 8'h00, 1'b0},
      // command byte still zero after reset: access answers zero
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h00, 17'h00000, 1'b1, 8'h00, 1'b0},
      // slot 1 not inserted yet
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b1, 8'hFF, 17'h00000, 1'b1, 8'hFF, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_IDLE,    1'b1, 8'hFF, 17'h0FFFF, 1'b1, 8'h00, 1'b0},
      // preload lands even with the slot empty
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_PRELOAD, 1'b1, 8'hFF, 17'h0FFFF, 1'b1, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_PRELOAD, 1'b0, 8'h5A, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b0, 8'hD0, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h00, 17'h00000, 1'b0, 8'h00, 1'b0},
      // write with post-increment, running off the end of the cartridge
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b0, 8'h2F, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h00, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'hFF, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h80, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h33, 17'h00000, 1'b1, 8'hFF, 1'b1},
      // an opcode with no meaning leaves everything alone
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b0, 8'h30, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h77, 17'h00000, 1'b0, 8'h00, 1'b0},
      // seek back to byte two, then read downward
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b0, 8'hAF, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h00, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h02, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b0, 8'h1F, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h00, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b0, 8'h00, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_SLOT1_PRESENT, MODE_IDLE,    1'b0, 8'h00, 17'd1,     1'b0, 8'h00, 1'b0},
      // full-size cartridge refuses writes
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b1, 8'hC0, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b1, 8'h11, 17'h00000, 1'b1, 8'hFF, 1'b0},
      // three seeks push the pointer to the top of the 24-bit range
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b1, 8'hA0, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b1, 8'hFF, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b1, 8'hFF, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b1, 8'hFF, 17'h00000, 1'b0, 8'h00, 1'b0},
      // read past the size answers zero and wraps the pointer to zero
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_CMD,     1'b1, 8'hDF, 17'h00000, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_SLOT0_SIZE,    MODE_ACCESS,  1'b1, 8'h00, 17'h00000, 1'b1, 8'h00, 1'b0}
   };

   // Sizes for the random phases; the first three phases pin the extremes
   bit [16:0] size_menu [12] = '{17'd0, 17'd1, 17'd2, 17'd16, 17'd100, 17'd255, 17'd256,
                                 17'd1000, 17'd32767, 17'd32768, 17'd65535, 17'd65536};
   bit [16:0] edge_size0 [3] = '{17'd0, 17'd32768, 17'd65535};
   bit [16:0] edge_size1 [3] = '{17'd65536, 17'd32767, 17'd1};

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [MODE_W-1:0]       req_mode = '0;
   logic                    req_slot = 1'b0;
   logic [DATA_W-1:0]       req_value = '0;
   logic [ADDR_IN_W-1:0]    req_load_addr = '0;
   logic                    rsp_strobe;
   logic [DATA_W-1:0]       rsp_read_byte;
   logic                    rsp_slot_dirty;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Shadow of the cartridge port: per-slot command, pointer, dirty flag and
   // configuration, plus an image of both cartridges with a loaded map so that
   // no read ever lands on a byte nobody wrote.
   bit [7:0]      cmd_byte [CART_SLOTS];
   bit [23:0]     cart_pos [CART_SLOTS];
   bit            dirty_flag [CART_SLOTS];
   bit [16:0]     cart_size [CART_SLOTS];
   bit            cart_present [CART_SLOTS];
   bit [7:0]      cart_image [CART_SLOTS*CART_BYTES];
   bit            image_valid [CART_SLOTS*CART_BYTES];

   cart_rsp_type  pending_rsp [$];
   cart_rsp_type  rsp_want;
   int            error_count = 0;
   int            burst_left = 1;
   bit            steady_sender = 1'b0;

   cartridge_memory_port dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_slot       (req_slot),
      .req_value      (req_value),
      .req_load_addr  (req_load_addr),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_slot_dirty (rsp_slot_dirty),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the response of one accepted beat and advance the shadow state.
   function automatic cart_rsp_type cartridge_response(cart_req_type r);
      cart_rsp_type  rsp;
      bit [23:0]     pos;
      bit [23:0]     mask;
      bit [16:0]     size;
      int            offset;
      bit            in_range;
      rsp.read_byte = BYTE_ZERO;
      case (r.mode)
         MODE_CMD: cmd_byte[r.slot] = r.value;
         MODE_PRELOAD: begin
            offset = int'(r.slot) * CART_BYTES + int'(r.load_addr);
            cart_image[offset] = r.value;
            image_valid[offset] = 1'b1;
         end
         MODE_ACCESS: begin
            if (!cart_present[r.slot]) begin
               rsp.read_byte = BYTE_ABSENT;
            end else begin
               pos = cart_pos[r.slot];
               size = cart_size[r.slot];
               // small cartridges wrap at 16 bits, the rest at 24
               mask = (size < SMALL_LIMIT) ? 24'h00FFFF : 24'hFFFFFF;
               offset = int'(r.slot) * CART_BYTES + int'(pos);
               in_range = (pos < size) && (pos < CART_BYTES);
               rsp.read_byte = BYTE_ABSENT;
               case (cmd_byte[r.slot][7:4])
                  CMD_ZERO: rsp.read_byte = BYTE_ZERO;
                  CMD_SEEK: pos = {pos[15:0], r.value} & mask;
                  CMD_READ_DEC, CMD_READ_INC: begin
                     rsp.read_byte = in_range ? cart_image[offset] : BYTE_ZERO;
                     pos = (cmd_byte[r.slot][CMD_READ_DIR_BIT] ? pos + 24'd1 : pos - 24'd1)
                           & mask;
                  end
                  CMD_WRITE, CMD_WRITE_ALT_C, CMD_WRITE_ALT_E: begin
                     if (in_range && size < SMALL_LIMIT) begin
                        cart_image[offset] = r.value;
                        image_valid[offset] = 1'b1;
                        dirty_flag[r.slot] = 1'b1;
                     end
                     pos = (cmd_byte[r.slot][CMD_WRITE_DIR_BIT] ? pos - 24'd1 : pos + 24'd1)
                           & mask;
                  end
                  default: ;
               endcase
               cart_pos[r.slot] = pos;
            end
         end
         default: ;
      endcase
      rsp.slot_dirty = dirty_flag[r.slot];
      return rsp;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      if (error_count < REPORT_CAP)
         $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
      error_count++;
   endtask

   // Write one register. Leave the write enable up: the next request beat drops it,
   // so back-to-back writes never fight over it within one step.
   task automatic program_register(logic [CSR_IDX_W-1:0] idx, bit [16:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we <= 1'b1;
      @(posedge clock);
      case (idx)
         CSR_SLOT0_SIZE:    cart_size[0] = data;
         CSR_SLOT1_SIZE:    cart_size[1] = data;
         CSR_SLOT0_PRESENT: cart_present[0] = data[0];
         CSR_SLOT1_PRESENT: cart_present[1] = data[0];
         default: ;
      endcase
   endtask

   // Present one beat, hold it until taken, then queue its response.
   // Between bursts drop start for a random gap unless the sender runs steady.
   task automatic issue_beat(cart_req_type b, bit typed, cart_rsp_type typed_rsp);
      cart_rsp_type predicted;
      csr_we <= 1'b0;
      start <= 1'b1;
      req_mode <= b.mode;
      req_slot <= b.slot;
      req_value <= b.value;
      req_load_addr <= b.load_addr;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = cartridge_response(b);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady_sender) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // Drop start and hold off until every response is in, plus the pipeline tail.
   task automatic settle_port();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response checker: every strobe must match the oldest queued response.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            flag_mismatch("response beat with nothing pending", int'(rsp_read_byte), 0);
         end else begin
            rsp_want = pending_rsp.pop_front();
            if (rsp_read_byte !== rsp_want.read_byte)
               flag_mismatch("read_byte", int'(rsp_read_byte), int'(rsp_want.read_byte));
            if (rsp_slot_dirty !== rsp_want.slot_dirty)
               flag_mismatch("slot_dirty", int'(rsp_slot_dirty), int'(rsp_want.slot_dirty));
         end
      end
   end

   // Hang detector: count cycles in which no beat of any kind moves.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1 || csr_we === 1'b1)
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      cart_req_type  beat;
      cart_req_type  fill;
      cart_rsp_type  typed_rsp;
      cart_rsp_type  no_rsp;
      plan_row_type  row;
      bit            beats_out;
      int            pick;
      bit [3:0]      opcode;
      bit [16:0]     size_pick;

      no_rsp = '{8'h00, 1'b0};
      beats_out = 1'b0;

      // Hold reset from time zero, then release it for good
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the plan, settling before any register write
      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR) begin
            if (beats_out) settle_port();
            beats_out = 1'b0;
            program_register(row.csr_idx, row.word);
         end else begin
            beat.mode = row.mode;
            beat.slot = row.slot;
            beat.value = row.value;
            beat.load_addr = row.word[15:0];
            typed_rsp.read_byte = row.want_byte;
            typed_rsp.slot_dirty = row.want_dirty;
            issue_beat(beat, row.typed, typed_rsp);
            beats_out = 1'b1;
         end
      end

      // Random part: each phase idles the port, reprograms both slots, then streams
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_port();
         for (int s = 0; s < CART_SLOTS; s++) begin
            if (phase < 3)
               size_pick = (s == 0) ? edge_size0[phase] : edge_size1[phase];
            else if ($urandom_range(0, 3) == 0)
               size_pick = 17'($urandom_range(0, 65536));
            else
               size_pick = size_menu[$urandom_range(0, 11)];
            program_register((s == 0) ? CSR_SLOT0_SIZE : CSR_SLOT1_SIZE, size_pick);
         end
         program_register(CSR_SLOT0_PRESENT,
                          17'((phase < 3) || ($urandom_range(0, 4) != 0)));
         program_register(CSR_SLOT1_PRESENT,
                          17'((phase < 3) || ($urandom_range(0, 4) != 0)));
         steady_sender = ($urandom_range(0, 3) == 0);

         for (int n = 0; n < PHASE_BEATS; n++) begin
            beat.slot = 1'($urandom_range(0, 1));
            beat.value = 8'($urandom_range(0, 255));
            beat.load_addr = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               // command write: mostly real opcodes, now and then a meaningless one
               beat.mode = MODE_CMD;
               case ($urandom_range(0, 9))
                  0: opcode = CMD_ZERO;
                  1: opcode = CMD_SEEK;
                  2: opcode = CMD_READ_DEC;
                  3: opcode = CMD_READ_INC;
                  4: opcode = CMD_WRITE;
                  5: opcode = CMD_WRITE_ALT_C;
                  6: opcode = CMD_WRITE_ALT_E;
                  default: opcode = 4'($urandom_range(0, 15));
               endcase
               beat.value[7:4] = opcode;
            end else if (pick < 75) begin
               // data access; zero seek bytes pull the pointer back into small sizes
               beat.mode = MODE_ACCESS;
               if (cmd_byte[beat.slot][7:4] == CMD_SEEK && $urandom_range(0, 1) == 0)
                  beat.value = 8'h00;
            end else if (pick < 92) begin
               // preload just ahead of the pointer, where reads will land
               beat.mode = MODE_PRELOAD;
               beat.load_addr = cart_pos[beat.slot][15:0] + 16'($urandom_range(0, 15));
            end else if (pick < 96) begin
               beat.mode = MODE_IDLE;
            end else begin
               beat.mode = MODE_PRELOAD;
            end

            // A read about to hit a byte never written: load that byte first
            if (beat.mode == MODE_ACCESS && cart_present[beat.slot]
                && (cmd_byte[beat.slot][7:4] == CMD_READ_DEC
                    || cmd_byte[beat.slot][7:4] == CMD_READ_INC)
                && cart_pos[beat.slot] < cart_size[beat.slot]
                && cart_pos[beat.slot] < CART_BYTES
                && !image_valid[int'(beat.slot) * CART_BYTES
                                + int'(cart_pos[beat.slot])]) begin
               fill.mode = MODE_PRELOAD;
               fill.slot = beat.slot;
               fill.value = 8'($urandom_range(0, 255));
               fill.load_addr = cart_pos[beat.slot][15:0];
               issue_beat(fill, 1'b0, no_rsp);
            end
            issue_beat(beat, 1'b0, no_rsp);
         end
      end

      // Drain everything still in flight, then give the verdict
      settle_port();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
